[design/psh_pkg.sv]
package psh_pkg;

  localparam int unsigned BatW = 10;
  localparam int unsigned ModeW = 3;

  localparam logic [BatW-1:0] CritLevelRst = 10'd440;

  localparam logic [ModeW-1:0] MODE_START = 3'd0;
  localparam logic [ModeW-1:0] MODE_SWOFF = 3'd1;
  localparam logic [ModeW-1:0] MODE_PWROFF = 3'd2;
  localparam logic [ModeW-1:0] MODE_WAIT = 3'd3;
  localparam logic [ModeW-1:0] MODE_FLAT = 3'd4;

  localparam logic [1:0] PER_1S = 2'd1;
  localparam logic [1:0] PER_2S = 2'd2;
  localparam logic [1:0] PER_3S = 2'd3;

  localparam int unsigned Per1Len = 1000;
  localparam int unsigned Per2Len = 2000;
  localparam int unsigned Per3Len = 3000;

  localparam logic [11:0] SlowOnUntil = 12'd20;
  localparam logic [11:0] WaitWindow = 12'd500;
  localparam logic [11:0] WaitBeat = 12'd250;
  localparam logic [11:0] WaitOnUntil = 12'd20;
  localparam logic [11:0] FlatWindow = 12'd600;
  localparam logic [11:0] FlatBeat = 12'd200;
  localparam logic [11:0] FlatOnUntil = 12'd15;

  typedef enum logic [4:0] {
    ST_START  = 5'b00001,
    ST_SWOFF  = 5'b00010,
    ST_PWROFF = 5'b00100,
    ST_WAIT   = 5'b01000,
    ST_FLAT   = 5'b10000
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic        led;
    logic        forced;
    logic [1:0]  period_sel;
    logic [9:0]  cnt1k;
    logic [10:0] cnt2k;
    logic [11:0] cnt3k;
  } psh_state_t;

  function automatic logic [ModeW-1:0] mode_code(mode_e m);
    logic [ModeW-1:0] code;
    case (m)
      ST_START:  code = MODE_START;
      ST_SWOFF:  code = MODE_SWOFF;
      ST_PWROFF: code = MODE_PWROFF;
      ST_WAIT:   code = MODE_WAIT;
      ST_FLAT:   code = MODE_FLAT;
      default:   code = MODE_START;
    endcase
    return code;
  endfunction

endpackage

[design/psh_in_if.sv]
interface psh_in_if import psh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            switch_open;
  logic            shutdown_request;
  logic            button_pressed;
  logic [BatW-1:0] battery_level;

  modport source (
    output valid, switch_open, shutdown_request, button_pressed, battery_level,
    input  ready
  );
  modport sink (
    input  valid, switch_open, shutdown_request, button_pressed, battery_level,
    output ready
  );
endinterface

[design/psh_out_if.sv]
interface psh_out_if import psh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             red_led_on;
  logic             regulator_forced_off;
  logic [ModeW-1:0] mode;

  modport source (
    output valid, red_led_on, regulator_forced_off, mode,
    input  ready
  );
  modport sink (
    input  valid, red_led_on, regulator_forced_off, mode,
    output ready
  );
endinterface

[design/psh_step.sv]
module psh_step import psh_pkg::*; (
  input  psh_state_t      state_i,
  input  logic            switch_open_i,
  input  logic            shutdown_request_i,
  input  logic            button_pressed_i,
  input  logic [BatW-1:0] battery_level_i,
  input  logic [BatW-1:0] crit_level_i,
  output psh_state_t      state_o
);

  logic        bat_flat;
  logic [9:0]  cnt1k_n;
  logic [10:0] cnt2k_n;
  logic [11:0] cnt3k_n;
  logic [11:0] phase;
  logic [11:0] phase_wait;
  logic [11:0] phase_flat;

  assign bat_flat = battery_level_i < crit_level_i;

  assign cnt1k_n = (state_i.cnt1k == 10'(Per1Len - 1)) ? '0 : state_i.cnt1k + 10'd1;
  assign cnt2k_n = (state_i.cnt2k == 11'(Per2Len - 1)) ? '0 : state_i.cnt2k + 11'd1;
  assign cnt3k_n = (state_i.cnt3k == 12'(Per3Len - 1)) ? '0 : state_i.cnt3k + 12'd1;

  always_comb begin
    case (state_i.period_sel)
      PER_2S:  phase = {1'b0, cnt2k_n};
      PER_3S:  phase = cnt3k_n;
      default: phase = {2'b00, cnt1k_n};
    endcase
  end

  assign phase_wait = (phase >= WaitBeat) ? phase - WaitBeat : phase;
  assign phase_flat = (phase >= 12'(2 * FlatBeat)) ? phase - 12'(2 * FlatBeat) :
                      (phase >= FlatBeat) ? phase - FlatBeat : phase;

  always_comb begin
    state_o = state_i;
    if (state_i.mode != ST_START) begin
      state_o.cnt1k = cnt1k_n;
      state_o.cnt2k = cnt2k_n;
      state_o.cnt3k = cnt3k_n;
    end
    case (state_i.mode)
      ST_START: begin
        state_o.cnt1k = '0;
        state_o.cnt2k = '0;
        state_o.cnt3k = '0;
        state_o.forced = 1'b0;
        if (!switch_open_i) begin
          state_o.period_sel = PER_3S;
          state_o.mode = ST_SWOFF;
        end else if (bat_flat) begin
          state_o.mode = ST_FLAT;
          state_o.period_sel = PER_2S;
          state_o.forced = 1'b1;
        end else begin
          state_o.mode = ST_WAIT;
        end
      end
      ST_SWOFF, ST_PWROFF: begin
        state_o.led = (phase <= SlowOnUntil);
        if (state_i.mode == ST_SWOFF || button_pressed_i) begin
          state_o.forced = 1'b0;
          if (!switch_open_i) begin
            state_o.period_sel = PER_3S;
            state_o.mode = ST_SWOFF;
          end else if (bat_flat) begin
            state_o.mode = ST_FLAT;
            state_o.period_sel = PER_2S;
            state_o.forced = 1'b1;
          end else begin
            state_o.mode = ST_WAIT;
            state_o.period_sel = PER_1S;
          end
        end
      end
      ST_WAIT: begin
        if (phase < WaitWindow) begin
          state_o.led = (phase_wait <= WaitOnUntil);
        end
        state_o.forced = 1'b0;
        if (!switch_open_i) begin
          state_o.period_sel = PER_3S;
          state_o.mode = ST_SWOFF;
        end else if (bat_flat) begin
          state_o.mode = ST_FLAT;
          state_o.period_sel = PER_2S;
          state_o.forced = 1'b1;
        end
        if (shutdown_request_i) begin
          state_o.forced = 1'b1;
          state_o.mode = ST_PWROFF;
        end
      end
      ST_FLAT: begin
        if (phase < FlatWindow) begin
          state_o.led = (phase_flat <= FlatOnUntil);
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

[design/power_supervisor_heartbeat.sv]
// Soft power supervisor, stepped by one word on the input channel per millisecond tick.
// Each input word carries the supply switch level, the host shutdown request, the power
// button and a battery sample; each produces exactly one output word with the red LED
// level, the regulator force-off flag and the current mode code.
// The first word after reset performs the start-up check; later words advance the
// heartbeat phase and move the supervisor between its modes.
// The battery threshold is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while no word is in flight, which the block does not enforce; it
// resets to 440 counts. The output word is valid in the cycle after acceptance, and a
// new word can be accepted every cycle while the receiver takes each word, set by the
// single state register that doubles as the output register.
// When the receiver stalls, the output word holds and the input channel is held off
// until that word is taken; a word arriving on the cycle it is taken is accepted.
// Reset, asynchronous and active low, returns the supervisor to the starting mode with
// the LED off, the regulator released and the output channel empty.
module power_supervisor_heartbeat import psh_pkg::*; #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [BatW-1:0] cfg_wdata_i,
  psh_in_if.sink          in_i,
  psh_out_if.source       out_o
);

  localparam logic [BatW-1:0] AdcMask =
    (ADC_BITS >= BatW) ? {BatW{1'b1}} : BatW'((1 << ADC_BITS) - 1);

  psh_state_t      state_q;
  psh_state_t      state_d;
  logic [BatW-1:0] crit_q;
  logic            out_valid_q;
  logic            accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && in_i.ready;

  psh_step u_step (
    .state_i            (state_q),
    .switch_open_i      (in_i.switch_open),
    .shutdown_request_i (in_i.shutdown_request),
    .button_pressed_i   (in_i.button_pressed),
    .battery_level_i    (in_i.battery_level & AdcMask),
    .crit_level_i       (crit_q & AdcMask),
    .state_o            (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q <= CritLevelRst;
    end else if (cfg_we_i) begin
      crit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode <= ST_START;
      state_q.led <= 1'b0;
      state_q.forced <= 1'b0;
      state_q.period_sel <= PER_1S;
      state_q.cnt1k <= '0;
      state_q.cnt2k <= '0;
      state_q.cnt3k <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.red_led_on = state_q.led;
  assign out_o.regulator_forced_off = state_q.forced;
  assign out_o.mode = mode_code(state_q.mode);

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.forced |-> (state_q.mode == ST_PWROFF || state_q.mode == ST_FLAT))
    else $error("regulator forced off outside power-off or battery-flat mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == ST_FLAT |=> state_q.mode == ST_FLAT)
    else $error("battery-flat mode left before reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no output word");
`endif

endmodule

[tb/power_supervisor_heartbeat_tb.sv]
`timescale 1ns / 100ps

module power_supervisor_heartbeat_tb import psh_pkg::*; ();

  localparam int unsigned ElapsedWrap = 6000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned LongHold = 60;
  localparam int unsigned MaxReports = 200;

  typedef struct packed {
    logic             led;
    logic             forced;
    logic [ModeW-1:0] mode;
  } status_t;

  class heartbeat_scoreboard;
    logic [BatW-1:0]  threshold;
    logic [ModeW-1:0] mode;
    bit               led;
    bit               forced;
    logic [1:0]       period_sel;
    int unsigned      elapsed;
    status_t          expected_words[$];
    int unsigned      errors;
    int unsigned      checked;
    bit [7:0]         seen_modes;

    function new();
      threshold = CritLevelRst;
      mode = MODE_START;
      led = 1'b0;
      forced = 1'b0;
      period_sel = PER_1S;
      elapsed = 0;
      errors = 0;
      checked = 0;
      seen_modes = '0;
    endfunction

    function bit release_regulator(bit sw);
      forced = 1'b0;
      if (!sw) begin
        period_sel = PER_3S;
        mode = MODE_SWOFF;
      end
      return sw;
    endfunction

    function bit battery_ok(logic [BatW-1:0] bat);
      if (bat < threshold) begin
        mode = MODE_FLAT;
        period_sel = PER_2S;
        forced = 1'b1;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void blink(int unsigned phase, int unsigned on_until);
      if (led) begin
        if (phase > on_until) led = 1'b0;
      end else if (phase <= on_until) begin
        led = 1'b1;
      end
    endfunction

    function void note_tick(bit sw, bit shut, bit btn, logic [BatW-1:0] bat);
      int unsigned period;
      int unsigned phase;
      status_t     word;
      if (mode == MODE_START) begin
        if (release_regulator(sw)) begin
          mode = MODE_WAIT;
          void'(battery_ok(bat));
        end
        elapsed = 0;
      end else if (mode <= MODE_FLAT) begin
        case (period_sel)
          PER_2S: period = Per2Len;
          PER_3S: period = Per3Len;
          default: period = Per1Len;
        endcase
        elapsed = (elapsed + 1) % ElapsedWrap;
        phase = elapsed % period;
        case (mode)
          MODE_SWOFF: begin
            blink(phase, SlowOnUntil);
            if (release_regulator(sw)) begin
              if (battery_ok(bat)) begin
                mode = MODE_WAIT;
                period_sel = PER_1S;
              end
            end
          end
          MODE_PWROFF: begin
            blink(phase, SlowOnUntil);
            if (btn) begin
              if (release_regulator(sw)) begin
                if (battery_ok(bat)) begin
                  period_sel = PER_1S;
                  mode = MODE_WAIT;
                end
              end
            end
          end
          MODE_WAIT: begin
            if (phase < WaitWindow) blink(phase % WaitBeat, WaitOnUntil);
            if (release_regulator(sw)) void'(battery_ok(bat));
            // A shutdown request overrides the switch and battery checks.
            if (shut) begin
              forced = 1'b1;
              mode = MODE_PWROFF;
            end
          end
          default: begin
            if (phase < FlatWindow) blink(phase % FlatBeat, FlatOnUntil);
          end
        endcase
      end
      word.led = led;
      word.forced = forced;
      word.mode = mode;
      expected_words.push_back(word);
      seen_modes[mode] = 1'b1;
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction

    function void mismatch(string field, logic [ModeW-1:0] want, logic [ModeW-1:0] got);
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_word(logic led_o, logic forced_o, logic [ModeW-1:0] mode_o);
      status_t want;
      checked++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: status word with none expected, expected nothing, actual %b/%b/%0d",
                   $time, led_o, forced_o, mode_o);
        end
        return;
      end
      want = expected_words.pop_front();
      if (led_o !== want.led) mismatch("red_led_on", ModeW'(want.led), ModeW'(led_o));
      if (forced_o !== want.forced) begin
        mismatch("regulator_forced_off", ModeW'(want.forced), ModeW'(forced_o));
      end
      if (mode_o !== want.mode) mismatch("mode", want.mode, mode_o);
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [BatW-1:0] cfg_wdata_i;

  psh_in_if  tick_bus ();
  psh_out_if status_bus ();

  power_supervisor_heartbeat u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (tick_bus),
    .out_o       (status_bus)
  );

  heartbeat_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned ticks_sent;
  int unsigned random_sent;
  int unsigned thresholds_used;
  bit          sw_level;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The long hold lets the block fill up and stall its input while ticks are still offered.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      status_bus.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LongHold - 1;
      status_bus.ready <= 1'b0;
    end else begin
      status_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (status_bus.valid === 1'b1 && status_bus.ready === 1'b1) begin
        sb.check_word(status_bus.red_led_on, status_bus.regulator_forced_off, status_bus.mode);
        quiet_cycles = 0;
      end else if (tick_bus.valid === 1'b1 && tick_bus.ready === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_tick(bit sw, bit shut, bit btn, logic [BatW-1:0] bat);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.switch_open <= sw;
    tick_bus.shutdown_request <= shut;
    tick_bus.button_pressed <= btn;
    tick_bus.battery_level <= bat;
    @(posedge clk_i);
    while (tick_bus.ready !== 1'b1) @(posedge clk_i);
    sb.note_tick(sw, shut, btn, bat);
    ticks_sent++;
  endtask

  task automatic set_threshold(logic [BatW-1:0] level);
    tick_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= level;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.threshold = level;
    thresholds_used++;
  endtask

  // The switch level changes rarely so that each mode is held long enough to see its pattern.
  // The battery is only checked with the switch on, so any sample is safe while it is off.
  task automatic run_random(int unsigned count, bit allow_flat);
    bit              sw;
    bit              shut;
    bit              btn;
    logic [BatW-1:0] bat;
    repeat (count) begin
      if (random_sent < 650) begin
        send_idle_pct = 8;
        stall_pct = 69;
      end else if (random_sent < 1300) begin
        send_idle_pct = 69;
        stall_pct = 8;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      if ($urandom_range(119) == 0) sw_level = !sw_level;
      sw = sw_level;
      if ($urandom_range(99) < 3) sw = !sw;
      shut = ($urandom_range(99) < 3);
      btn = ($urandom_range(99) < 6);
      if (!sw || (allow_flat && $urandom_range(39) == 0)) begin
        bat = $urandom_range(1023, 0);
      end else begin
        bat = $urandom_range(1023, sb.threshold);
      end
      send_tick(sw, shut, btn, bat);
      random_sent++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    tick_bus.valid = 1'b0;
    tick_bus.switch_open = 1'b0;
    tick_bus.shutdown_request = 1'b0;
    tick_bus.button_pressed = 1'b0;
    tick_bus.battery_level = '0;
    status_bus.ready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    ticks_sent = 0;
    random_sent = 0;
    thresholds_used = 0;
    send_idle_pct = 0;
    stall_pct = 30;
    sw_level = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(1'b0, 1'b1, 1'b1, 10'd0);
    send_tick(1'b0, 1'b1, 1'b1, 10'd0);
    send_tick(1'b1, 1'b0, 1'b0, 10'd440);
    send_tick(1'b1, 1'b1, 1'b0, 10'd1023);
    send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
    send_tick(1'b0, 1'b0, 1'b1, 10'd511);
    send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
    send_tick(1'b0, 1'b1, 1'b0, 10'd0);
    send_tick(1'b1, 1'b0, 1'b1, 10'd441);
    send_tick(1'b1, 1'b0, 1'b1, 10'd1022);
    send_tick(1'b1, 1'b1, 1'b1, 10'd512);
    send_tick(1'b1, 1'b0, 1'b1, 10'd1023);
    run_random(500, 1'b0);

    set_threshold(10'd0);
    send_tick(1'b1, 1'b0, 1'b0, 10'd0);
    hold_req = 1'b1;
    run_random(350, 1'b0);

    set_threshold(10'd1023);
    send_tick(1'b1, 1'b0, 1'b0, 10'd1023);
    run_random(250, 1'b0);

    set_threshold(10'($urandom_range(1022, 1)));
    run_random(350, 1'b0);

    // The flat battery mode holds until reset, so it is only allowed in the last stretch.
    set_threshold(10'($urandom_range(900, 300)));
    run_random(500, 1'b1);

    tick_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d ticks under %0d battery thresholds, checked %0d status words, %0d errors.",
             ticks_sent, thresholds_used + 1, sb.checked, sb.errors);
    $display("Modes reached, one bit per mode code from flat down to starting: %b",
             sb.seen_modes[4:0]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[power_supervisor_heartbeat.f]
design/psh_pkg.sv
design/psh_in_if.sv
design/psh_out_if.sv
design/psh_step.sv
design/power_supervisor_heartbeat.sv
tb/power_supervisor_heartbeat_tb.sv
